/* src/lpcp_pkg.sv */
`timescale 1ns / 1ps
// lpcp_pkg: shared types and constants of the lidar point to camera projection block
// no dependencies

package lpcp_pkg;

  localparam int COEF_WIDTH       = 32;
  localparam int NUM_COEFS        = 12;
  localparam int COEF_INDEX_WIDTH = 4;
  localparam int DIM_WIDTH        = 13;
  localparam int FULL_SCALE_WIDTH = 31;
  localparam int GRAY_WIDTH       = 8;
  localparam int CFG_INDEX_WIDTH  = 2;
  localparam int CFG_DATA_WIDTH   = 32;

  // pixel quotients stay below 2^13
  localparam int QUOT_BITS = 13;

  // 255*255 = 2^16 - 2^9 + 1
  localparam int GRAY_SQ_SHIFT_HI = 16;
  localparam int GRAY_SQ_SHIFT_LO = 9;

  localparam logic [GRAY_WIDTH-1:0]       GRAY_MAX            = 8'd255;
  localparam logic [DIM_WIDTH-1:0]        IMAGE_WIDTH_RESET   = 13'd1920;
  localparam logic [DIM_WIDTH-1:0]        IMAGE_HEIGHT_RESET  = 13'd1208;
  localparam logic [FULL_SCALE_WIDTH-1:0] FULL_SCALE_RESET    = 31'd327680;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_PROJECT = 1'b1;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_FULL_SCALE   = 2'd2
  } reg_index_t;

endpackage

/* src/lpcp_point_if.sv */
`timescale 1ns / 1ps
// lpcp_point_if: input word channel (coefficient loads and points)
// depends on lpcp_pkg

interface lpcp_point_if #(parameter int COORD_WIDTH = 32);
  logic valid;
  logic ready;
  logic command;
  logic [lpcp_pkg::COEF_INDEX_WIDTH-1:0] coef_index;
  logic signed [lpcp_pkg::COEF_WIDTH-1:0] coef_value;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] point_z;

  modport source (output valid, command, coef_index, coef_value, point_x, point_y, point_z,
                  input ready);
  modport sink (input valid, command, coef_index, coef_value, point_x, point_y, point_z,
                output ready);
endinterface

/* src/lpcp_pixel_if.sv */
`timescale 1ns / 1ps
// lpcp_pixel_if: output word channel (pixel writes)
// depends on lpcp_pkg

interface lpcp_pixel_if #(parameter int PIXEL_COORD_WIDTH = 12);
  logic valid;
  logic ready;
  logic [PIXEL_COORD_WIDTH-1:0] pixel_col;
  logic [PIXEL_COORD_WIDTH-1:0] pixel_row;
  logic [lpcp_pkg::GRAY_WIDTH-1:0] gray_level;
  logic last_of_point;

  modport source (output valid, pixel_col, pixel_row, gray_level, last_of_point, input ready);
  modport sink (input valid, pixel_col, pixel_row, gray_level, last_of_point, output ready);
endinterface

/* src/lpcp_cfg_if.sv */
`timescale 1ns / 1ps
// lpcp_cfg_if: register write channel
// depends on lpcp_pkg

interface lpcp_cfg_if;
  logic valid;
  logic ready;
  logic [lpcp_pkg::CFG_INDEX_WIDTH-1:0] index;
  logic [lpcp_pkg::CFG_DATA_WIDTH-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* src/lidar_point_camera_projection.sv */
`timescale 1ns / 1ps
// lidar_point_camera_projection: projects lidar points to camera pixels with a gray level
// depends on lpcp_pkg, lpcp_point_if, lpcp_pixel_if, lpcp_cfg_if
//
// usage
//   points : input words; command load writes one of twelve matrix entries (row-major,
//            signed Q16.16), command project sends a point (x, y, z)
//   pixels : output words; one pixel per in-frame point, or four (pixel, right,
//            lower-right, lower) when the neighbours are in frame; last_of_point marks
//            the final word of a point
//   regs   : register writes (image width, image height, full scale distance),
//            always ready; write only while the block is idle
// pipeline: an accepted point passes one product stage, one sum stage, a one-bit-per-stage
//   square root of COORD_WIDTH + 9 stages, gray quotient prep and eight quotient stages,
//   then the output register
// throughput: one point per cycle unless stalled; a four-pixel point holds the output
//   register through its last word, so ready stays low while its neighbours go out
// a load word leaves the coefficients written at the accept edge and uses no stage
// reset clears every valid bit and the registers to 1920, 1208 and 5.0 m; the matrix
//   is undefined until loaded
// when the receiver stalls the whole pipeline freezes in place and ready drops

module lidar_point_camera_projection #(
  parameter int COORD_WIDTH       = 32,
  parameter int FRAC_BITS         = 16,
  parameter int PIXEL_COORD_WIDTH = 12
) (
  input  logic clk,
  input  logic rst,
  lpcp_point_if.sink   points,
  lpcp_pixel_if.source pixels,
  lpcp_cfg_if.sink     regs
);

  localparam int CW     = COORD_WIDTH;
  localparam int QB     = lpcp_pkg::QUOT_BITS;
  localparam int GB     = lpcp_pkg::GRAY_WIDTH;
  localparam int CFW    = lpcp_pkg::COEF_WIDTH;
  localparam int PROD_W = CFW + CW;
  localparam int CONST_W = CFW + FRAC_BITS + 1;
  // u, v, w: sum of four terms
  localparam int PW     = ((PROD_W > CONST_W) ? PROD_W : CONST_W) + 2;
  localparam int DW     = PW + QB + 1;
  localparam int D2W    = 2 * CW + 2;
  localparam int RHW    = D2W + lpcp_pkg::GRAY_SQ_SHIFT_HI;
  localparam int RW     = (RHW + 1) / 2;
  localparam int SW     = RHW + 2;
  localparam int GW     = ((RW > lpcp_pkg::FULL_SCALE_WIDTH + GB) ? RW
                           : lpcp_pkg::FULL_SCALE_WIDTH + GB) + 1;
  // square root steps, gray prep, gray quotient steps
  localparam int NC     = RW + 1 + GB;
  localparam int XW     = QB + 1;

  typedef struct packed {
    logic          v;
    logic          wpos;
    logic          bad;
    logic          zu;
    logic          zv;
    logic [DW-1:0] den;
    logic [DW-1:0] ru;
    logic [DW-1:0] rv;
    logic [QB-1:0] qu;
    logic [QB-1:0] qv;
    logic [SW-1:0] srem;
    logic [RW-1:0] root;
    logic [GW-1:0] grem;
    logic [GB-1:0] g;
    logic          gsat;
  } step_t;

  // configuration registers
  logic [lpcp_pkg::DIM_WIDTH-1:0]        image_width;
  logic [lpcp_pkg::DIM_WIDTH-1:0]        image_height;
  logic [lpcp_pkg::FULL_SCALE_WIDTH-1:0] full_scale;

  assign regs.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= lpcp_pkg::IMAGE_WIDTH_RESET;
      image_height <= lpcp_pkg::IMAGE_HEIGHT_RESET;
      full_scale   <= lpcp_pkg::FULL_SCALE_RESET;
    end else if (regs.valid) begin
      case (lpcp_pkg::reg_index_t'(regs.index))
        lpcp_pkg::REG_IMAGE_WIDTH:  image_width  <= regs.data[lpcp_pkg::DIM_WIDTH-1:0];
        lpcp_pkg::REG_IMAGE_HEIGHT: image_height <= regs.data[lpcp_pkg::DIM_WIDTH-1:0];
        lpcp_pkg::REG_FULL_SCALE:   full_scale <= regs.data[lpcp_pkg::FULL_SCALE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advance: everything moves when the output register can take a new point
  logic adv;
  logic accept;
  assign points.ready = adv;
  assign accept = points.valid && adv;

  // projection matrix, undefined until loaded
  logic signed [CFW-1:0] coef [lpcp_pkg::NUM_COEFS];

  always_ff @(posedge clk) begin
    if (accept && points.command == lpcp_pkg::CMD_LOAD &&
        points.coef_index < lpcp_pkg::COEF_INDEX_WIDTH'(lpcp_pkg::NUM_COEFS)) begin
      coef[points.coef_index] <= points.coef_value;
    end
  end

  // stage 1: products
  logic                      v0;
  logic signed [PROD_W-1:0]  prod [9];
  logic signed [CONST_W-1:0] cst [3];
  logic signed [2*CW-1:0]    sq [3];
  logic signed [CW-1:0]      pt [3];

  assign pt[0] = points.point_x;
  assign pt[1] = points.point_y;
  assign pt[2] = points.point_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= accept && points.command == lpcp_pkg::CMD_PROJECT;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          prod[r*3+k] <= PROD_W'(coef[r*4+k]) * PROD_W'(pt[k]);
        end
        cst[r] <= CONST_W'(coef[r*4+3]) <<< FRAC_BITS;
        sq[r]  <= (2*CW)'(pt[r]) * (2*CW)'(pt[r]);
      end
    end
  end

  // stage 2: u, v, w and squared range
  logic                 v1;
  logic signed [PW-1:0] su, sv, sw;
  logic [D2W-1:0]       d2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      su <= PW'(prod[0]) + PW'(prod[1]) + PW'(prod[2]) + PW'(cst[0]);
      sv <= PW'(prod[3]) + PW'(prod[4]) + PW'(prod[5]) + PW'(cst[1]);
      sw <= PW'(prod[6]) + PW'(prod[7]) + PW'(prod[8]) + PW'(cst[2]);
      d2 <= D2W'($unsigned(sq[0])) + D2W'($unsigned(sq[1])) + D2W'($unsigned(sq[2]));
    end
  end

  // quotient range checks and first state of the digit chain
  logic signed [DW-1:0] nu, nv, dd;
  logic [RHW-1:0]       d2x, rhs;
  logic                 neg_u, neg_v, ovf_u, ovf_v;
  step_t                st_init;

  always_comb begin
    nu    = DW'(su);
    nv    = DW'(sv);
    dd    = DW'(sw);
    neg_u = (nu + dd) <= 0;
    neg_v = (nv + dd) <= 0;
    ovf_u = nu >= (dd <<< QB);
    ovf_v = nv >= (dd <<< QB);
    d2x   = RHW'(d2);
    // 65025 * d2
    rhs   = (d2x << lpcp_pkg::GRAY_SQ_SHIFT_HI) - (d2x << lpcp_pkg::GRAY_SQ_SHIFT_LO) + d2x;

    st_init      = '0;
    st_init.v    = v1;
    st_init.wpos = sw > 0;
    st_init.bad  = neg_u || neg_v || ovf_u || ovf_v;
    // a small negative quotient passes the bound test whatever the bound
    st_init.zu   = nu[DW-1];
    st_init.zv   = nv[DW-1];
    st_init.den  = dd;
    // a small negative quotient truncates to zero
    st_init.ru   = nu[DW-1] ? '0 : nu;
    st_init.rv   = nv[DW-1] ? '0 : nv;
    st_init.srem = SW'(rhs);
  end

  // digit chain: pixel quotients and square root one bit per stage, then gray quotient
  step_t st [NC];

  for (genvar j = 0; j < NC; j++) begin : g_step
    step_t         p, n;
    logic [DW-1:0] ru_n, rv_n;
    logic [QB-1:0] qu_n, qv_n;
    logic [SW-1:0] srem_n;
    logic [RW-1:0] root_n;
    logic [GW-1:0] grem_n;
    logic [GB-1:0] g_n;
    logic          gsat_n;

    if (j == 0) begin : g_first
      assign p = st_init;
    end else begin : g_next
      assign p = st[j-1];
    end

    if (j < QB) begin : g_pix
      localparam int B = QB - 1 - j;
      logic signed [DW-1:0] tu, tv;
      assign tu   = $signed(p.ru) - ($signed(p.den) <<< B);
      assign tv   = $signed(p.rv) - ($signed(p.den) <<< B);
      assign ru_n = tu[DW-1] ? p.ru : tu;
      assign rv_n = tv[DW-1] ? p.rv : tv;
      assign qu_n = tu[DW-1] ? p.qu : (p.qu | (QB'(1) << B));
      assign qv_n = tv[DW-1] ? p.qv : (p.qv | (QB'(1) << B));
    end else begin : g_pix_hold
      assign ru_n = p.ru;
      assign rv_n = p.rv;
      assign qu_n = p.qu;
      assign qv_n = p.qv;
    end

    if (j < RW) begin : g_sqrt
      localparam int I = RW - 1 - j;
      logic [SW-1:0] trial;
      logic          ge;
      assign trial  = (SW'(p.root) << (I + 1)) + (SW'(1) << (2 * I));
      assign ge     = p.srem >= trial;
      assign srem_n = ge ? p.srem - trial : p.srem;
      assign root_n = ge ? (p.root | (RW'(1) << I)) : p.root;
      assign grem_n = p.grem;
      assign g_n    = p.g;
      assign gsat_n = p.gsat;
    end else if (j == RW) begin : g_gprep
      assign srem_n = p.srem;
      assign root_n = p.root;
      assign grem_n = GW'(p.root);
      assign g_n    = '0;
      assign gsat_n = (full_scale == '0) || (GW'(p.root) >= (GW'(full_scale) << GB));
    end else begin : g_gdiv
      localparam int B = GB - 1 - (j - RW - 1);
      logic [GW-1:0] fsh;
      logic          ge;
      assign fsh    = GW'(full_scale) << B;
      assign ge     = p.grem >= fsh;
      assign srem_n = p.srem;
      assign root_n = p.root;
      assign grem_n = ge ? p.grem - fsh : p.grem;
      assign g_n    = ge ? (p.g | (GB'(1) << B)) : p.g;
      assign gsat_n = p.gsat;
    end

    always_comb begin
      n      = p;
      n.ru   = ru_n;
      n.rv   = rv_n;
      n.qu   = qu_n;
      n.qv   = qv_n;
      n.srem = srem_n;
      n.root = root_n;
      n.grem = grem_n;
      n.g    = g_n;
      n.gsat = gsat_n;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st[j].v <= 1'b0;
      end else if (adv) begin
        st[j] <= n;
      end
    end
  end

  // frame test on the finished point
  step_t         fin;
  logic          fin_ok;
  logic [XW-1:0] fin_col, fin_row;
  logic [GB-1:0] fin_gray;

  assign fin      = st[NC-1];
  assign fin_col  = XW'(fin.qu);
  assign fin_row  = XW'(fin.qv);
  assign fin_gray = fin.gsat ? lpcp_pkg::GRAY_MAX : fin.g;
  assign fin_ok   = fin.v && fin.wpos && !fin.bad &&
                    (fin.qu < image_width || fin.zu) &&
                    (fin.qv < image_height || fin.zv);

  // output register: sends the pixel and, if in frame, its three neighbours
  logic          hold_v;
  logic [XW-1:0] h_col, h_row;
  logic [GB-1:0] h_gray;
  logic          h_quad;
  logic [1:0]    h_cnt;
  logic          out_last;
  logic [XW-1:0] o_col, o_row;

  assign out_last = !h_quad || h_cnt == 2'd3;
  assign adv      = !hold_v || (pixels.ready && out_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_v <= 1'b0;
      h_cnt  <= '0;
    end else if (adv) begin
      hold_v <= fin_ok;
      h_cnt  <= '0;
    end else if (pixels.ready) begin
      h_cnt <= h_cnt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h_col  <= fin_col;
      h_row  <= fin_row;
      h_gray <= fin_gray;
      h_quad <= (fin_col + XW'(1)) < XW'(image_width) &&
                (fin_row + XW'(1)) < XW'(image_height);
    end
  end

  // word order: pixel, right, lower-right, lower
  assign o_col = (h_cnt == 2'd1 || h_cnt == 2'd2) ? h_col + XW'(1) : h_col;
  assign o_row = (h_cnt == 2'd2 || h_cnt == 2'd3) ? h_row + XW'(1) : h_row;

  assign pixels.valid         = hold_v;
  assign pixels.pixel_col     = o_col[PIXEL_COORD_WIDTH-1:0];
  assign pixels.pixel_row     = o_row[PIXEL_COORD_WIDTH-1:0];
  assign pixels.gray_level    = h_gray;
  assign pixels.last_of_point = out_last;

endmodule

/* src/lpcp_checker.sv */
`timescale 1ns / 1ps
// lpcp_checker: port-level assertions for lidar_point_camera_projection, and its bind
// depends on lpcp_pkg and the top level

module lpcp_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [lpcp_pkg::GRAY_WIDTH-1:0] gray_level,
  input logic                           last_of_point
);

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(gray_level) && $stable(last_of_point))
    else $error("stalled pixel word changed");

  // neighbours of a point follow at once with the same gray level
  a_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_of_point |=> out_valid && $stable(gray_level))
    else $error("pixel burst broken");

  // input is held off only by a pending pixel word
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

  // nothing leaves right after reset
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("pixel word after reset");

endmodule

bind lidar_point_camera_projection lpcp_checker u_lpcp_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (points.ready),
  .out_valid     (pixels.valid),
  .out_ready     (pixels.ready),
  .gray_level    (pixels.gray_level),
  .last_of_point (pixels.last_of_point)
);
